### hw/rtl/prp3d_pkg.sv
// ----------------------------------------------------------------------------
// prp3d_pkg
// Shared widths, types and register codes for the vertex projection pipeline.
// ----------------------------------------------------------------------------
package prp3d_pkg;

  localparam int TRIG_FRAC_BITS = 14;
  localparam int COORD_BITS     = 12;

  localparam int COL_W      = 12;
  localparam int ELEV_W     = 16;
  localparam int COLOR_W    = 24;
  localparam int OUT_W      = 16;
  localparam int TRIG_W     = 16;
  localparam int SCALE_W    = 16;
  localparam int OFF_W      = 16;
  localparam int MAP_W      = 13;
  localparam int DS_W       = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int WIDE_W     = 64;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Column / row bits actually used
  localparam int CU_W  = (COORD_BITS < COL_W) ? COORD_BITS : COL_W;
  // Centered coordinates in half units
  localparam int CX_W  = imax(CU_W + 1, MAP_W) + 2;
  localparam int CZ_W  = imax(ELEV_W + 1, DS_W) + 1;
  // First rotation products and sums
  localparam int AB_W  = TRIG_W + imax(CX_W, CZ_W);
  localparam int PX_W  = imax(AB_W, CX_W + TRIG_FRAC_BITS) + 1;
  // Second rotation products and pre-round sums
  localparam int EF_W  = TRIG_W + imax(PX_W, CX_W);
  localparam int PYR_W = imax(EF_W, TRIG_W + CX_W + TRIG_FRAC_BITS) + 1;
  localparam int PY_W  = imax(PYR_W - TRIG_FRAC_BITS, PX_W);
  localparam int PZ_W  = imax(PYR_W - TRIG_FRAC_BITS, CZ_W + TRIG_FRAC_BITS) + 1;
  // Scaling and final offset
  localparam int FIN_SH = TRIG_FRAC_BITS + 9;
  localparam int MX_W  = PX_W + SCALE_W + 1;
  localparam int MY_W  = PY_W + SCALE_W + 1;
  localparam int SX_W  = imax(MX_W, OFF_W + FIN_SH) + 1;
  localparam int SY_W  = imax(MY_W, OFF_W + FIN_SH) + 1;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [OFF_W-1:0]  off_t;
  typedef logic signed [CX_W-1:0]   cx_t;
  typedef logic signed [CZ_W-1:0]   cz_t;
  typedef logic signed [AB_W-1:0]   ab_t;
  typedef logic signed [PX_W-1:0]   px_t;
  typedef logic signed [EF_W-1:0]   ef_t;
  typedef logic signed [PYR_W-1:0]  pyr_t;
  typedef logic signed [PY_W-1:0]   py_t;
  typedef logic signed [PZ_W-1:0]   pz_t;
  typedef logic signed [MX_W-1:0]   mx_t;
  typedef logic signed [MY_W-1:0]   my_t;
  typedef logic signed [SX_W-1:0]   sx_t;
  typedef logic signed [SY_W-1:0]   sy_t;
  typedef logic signed [OUT_W-1:0]  out_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [COLOR_W-1:0]       color_t;

  typedef enum logic {
    MODE_ROTATE,
    MODE_OBLIQUE
  } proj_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE,
    CFG_ROT_Y,
    CFG_ROT_X,
    CFG_SCALE,
    CFG_OFFSET,
    CFG_MAP_W,
    CFG_MAP_H,
    CFG_DEPTH_SUM
  } cfg_reg_e;

  typedef struct packed {
    proj_mode_e       mode;
    logic [31:0]      rot_y;
    logic [31:0]      rot_x;
    logic [SCALE_W-1:0] scale;
    logic [31:0]      offset;
    logic [MAP_W-1:0] map_width;
    logic [MAP_W-1:0] map_height;
    logic [DS_W-1:0]  depth_sum;
  } cfg_t;

  localparam logic [31:0]        TRIG_RST  = 32'h4000_0000;
  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd256;
  localparam logic [MAP_W-1:0]   MAP_RST   = 13'd1;

endpackage

### hw/rtl/prp3d_cfg.sv
// ----------------------------------------------------------------------------
// prp3d_cfg
// Configuration register file; one register written per beat.
// ----------------------------------------------------------------------------
module prp3d_cfg
  import prp3d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_reg_e idx;

  assign cfg_ready = 1'b1;
  assign idx       = cfg_reg_e'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= MODE_ROTATE;
      cfg.rot_y      <= TRIG_RST;
      cfg.rot_x      <= TRIG_RST;
      cfg.scale      <= SCALE_RST;
      cfg.offset     <= '0;
      cfg.map_width  <= MAP_RST;
      cfg.map_height <= MAP_RST;
      cfg.depth_sum  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (idx)
        CFG_MODE:      cfg.mode       <= proj_mode_e'(cfg_data[0]);
        CFG_ROT_Y:     cfg.rot_y      <= cfg_data[31:0];
        CFG_ROT_X:     cfg.rot_x      <= cfg_data[31:0];
        CFG_SCALE:     cfg.scale      <= cfg_data[SCALE_W-1:0];
        CFG_OFFSET:    cfg.offset     <= cfg_data[31:0];
        CFG_MAP_W:     cfg.map_width  <= cfg_data[MAP_W-1:0];
        CFG_MAP_H:     cfg.map_height <= cfg_data[MAP_W-1:0];
        CFG_DEPTH_SUM: cfg.depth_sum  <= cfg_data[DS_W-1:0];
        default:       cfg.mode       <= cfg.mode;
      endcase
    end
  end

`ifndef SYNTH
  a_scale_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && idx == CFG_SCALE) |=> cfg.scale == $past(cfg_data[SCALE_W-1:0]))
    else $error("scale register did not take the written beat");

  a_mode_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && idx == CFG_MODE) |=> cfg.mode == $past(cfg_data[0]))
    else $error("projection mode did not take the written beat");
`endif

endmodule

### hw/rtl/prp3d_center.sv
// ----------------------------------------------------------------------------
// prp3d_center
// Stage 1: center the vertex on the map in half units.
// ----------------------------------------------------------------------------
module prp3d_center
  import prp3d_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     v_in,
  output logic                     up_en,
  input  logic [COL_W-1:0]         col,
  input  logic [COL_W-1:0]         row,
  input  logic signed [ELEV_W-1:0] elevation,
  input  color_t                   color,
  output logic                     v_out,
  input  logic                     down_en,
  output cx_t                      cx2,
  output cx_t                      cy2,
  output cz_t                      cz2,
  output color_t                   color_q
);

  logic en;
  cx_t  cx2_next;
  cx_t  cy2_next;
  cz_t  cz2_next;

  assign en    = !v_out || down_en;
  assign up_en = en;

  always_comb begin
    cx2_next = cx_t'({1'b0, col[CU_W-1:0], 1'b0}) - cx_t'(cfg.map_width) + cx_t'(1);
    cy2_next = cx_t'({1'b0, row[CU_W-1:0], 1'b0}) - cx_t'(cfg.map_height) + cx_t'(1);
    cz2_next = (cz_t'(elevation) <<< 1) - cz_t'($signed(cfg.depth_sum));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx2     <= cx2_next;
      cy2     <= cy2_next;
      cz2     <= cz2_next;
      color_q <= color;
    end
  end

endmodule

### hw/rtl/prp3d_rotate.sv
// ----------------------------------------------------------------------------
// prp3d_rotate
// Stages 2..5: rotation about Y then X, or oblique shear.
// ----------------------------------------------------------------------------
module prp3d_rotate
  import prp3d_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   v_in,
  output logic   up_en,
  input  cx_t    cx2,
  input  cx_t    cy2,
  input  cz_t    cz2,
  input  color_t color_in,
  output logic   v_out,
  input  logic   down_en,
  output px_t    px,
  output py_t    py,
  output pz_t    pz,
  output color_t color_q
);

  trig_t cy, sy, cx, sx;
  logic  en2, en3, en4, en5;
  logic  v2, v3, v4;

  // stage 2: first products
  ab_t    s2_a, s2_b, s2_c, s2_d;
  cx_t    s2_cx2, s2_cy2;
  cz_t    s2_cz2;
  color_t s2_color;
  // stage 3: px, z1 and oblique y
  px_t    s3_px, s3_z1;
  py_t    s3_pyo;
  cx_t    s3_cy2;
  cz_t    s3_cz2;
  color_t s3_color;
  // stage 4: second products
  ef_t    s4_e, s4_f, s4_g, s4_h;
  px_t    s4_px;
  py_t    s4_pyo;
  cz_t    s4_cz2;
  color_t s4_color;
  // stage 5 combinational
  pyr_t   ry, rz;
  py_t    py_next;
  pz_t    pz_next;

  assign cy = trig_t'(cfg.rot_y[31:16]);
  assign sy = trig_t'(cfg.rot_y[15:0]);
  assign cx = trig_t'(cfg.rot_x[31:16]);
  assign sx = trig_t'(cfg.rot_x[15:0]);

  // Advance a stage when it is empty or the next one moves
  assign en5   = !v_out || down_en;
  assign en4   = !v4 || en5;
  assign en3   = !v3 || en4;
  assign en2   = !v2 || en3;
  assign up_en = en2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      v_out <= 1'b0;
    end else begin
      if (en2) v2 <= v_in;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v_out <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_a     <= ab_t'(cy) * ab_t'(cx2);
      s2_b     <= ab_t'(sy) * ab_t'(cz2);
      s2_c     <= ab_t'(cy) * ab_t'(cz2);
      s2_d     <= ab_t'(sy) * ab_t'(cx2);
      s2_cx2   <= cx2;
      s2_cy2   <= cy2;
      s2_cz2   <= cz2;
      s2_color <= color_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      if (cfg.mode == MODE_OBLIQUE) begin
        s3_px <= (px_t'(s2_cx2) <<< TRIG_FRAC_BITS) - px_t'(s2_c);
      end else begin
        s3_px <= px_t'(s2_a) + px_t'(s2_b);
      end
      s3_z1    <= px_t'(s2_c) - px_t'(s2_d);
      s3_pyo   <= (py_t'(s2_cy2) <<< TRIG_FRAC_BITS) - py_t'(s2_b);
      s3_cy2   <= s2_cy2;
      s3_cz2   <= s2_cz2;
      s3_color <= s2_color;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_e     <= ef_t'(cx) * ef_t'(s3_cy2);
      s4_f     <= ef_t'(sx) * ef_t'(s3_z1);
      s4_g     <= ef_t'(sx) * ef_t'(s3_cy2);
      s4_h     <= ef_t'(cx) * ef_t'(s3_z1);
      s4_px    <= s3_px;
      s4_pyo   <= s3_pyo;
      s4_cz2   <= s3_cz2;
      s4_color <= s3_color;
    end
  end

  // Round to nearest, halves up: add half then shift arithmetically
  always_comb begin
    ry = (pyr_t'(s4_e) <<< TRIG_FRAC_BITS) - pyr_t'(s4_f)
         + (pyr_t'(1) <<< (TRIG_FRAC_BITS - 1));
    rz = (pyr_t'(s4_g) <<< TRIG_FRAC_BITS) + pyr_t'(s4_h)
         + (pyr_t'(1) <<< (TRIG_FRAC_BITS - 1));
    if (cfg.mode == MODE_OBLIQUE) begin
      py_next = s4_pyo;
      pz_next = pz_t'(s4_cz2) <<< TRIG_FRAC_BITS;
    end else begin
      py_next = py_t'(ry >>> TRIG_FRAC_BITS);
      pz_next = pz_t'(rz >>> TRIG_FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      px      <= s4_px;
      py      <= py_next;
      pz      <= pz_next;
      color_q <= s4_color;
    end
  end

endmodule

### hw/rtl/prp3d_screen.sv
// ----------------------------------------------------------------------------
// prp3d_screen
// Stages 6..7: zoom, screen offset, rounding and saturation to pixels.
// ----------------------------------------------------------------------------
module prp3d_screen
  import prp3d_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   v_in,
  output logic   up_en,
  input  px_t    px,
  input  py_t    py,
  input  pz_t    pz,
  input  color_t color_in,
  output logic   out_valid,
  input  logic   out_stall,
  output out_t   screen_x,
  output out_t   screen_y,
  output out_t   view_depth,
  output color_t color_out
);

  logic   en6, en7, v6;
  mx_t    s6_mx;
  my_t    s6_my;
  pz_t    s6_rz;
  color_t s6_color;
  sx_t    sum_x;
  sy_t    sum_y;
  off_t   offx, offy;

  function automatic out_t sat_out(input wide_t v);
    wide_t hi, lo;
    hi = wide_t'(2 ** (OUT_W - 1) - 1);
    lo = -wide_t'(2 ** (OUT_W - 1));
    if (v > hi) begin
      return out_t'(hi);
    end else if (v < lo) begin
      return out_t'(lo);
    end
    return out_t'(v);
  endfunction

  assign offx  = off_t'(cfg.offset[31:16]);
  assign offy  = off_t'(cfg.offset[15:0]);

  assign en7   = !out_valid || !out_stall;
  assign en6   = !v6 || en7;
  assign up_en = en6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en6) v6 <= v_in;
      if (en7) out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_mx    <= mx_t'(px) * mx_t'({1'b0, cfg.scale});
      s6_my    <= my_t'(py) * my_t'({1'b0, cfg.scale});
      s6_rz    <= (pz + (pz_t'(1) <<< TRIG_FRAC_BITS)) >>> (TRIG_FRAC_BITS + 1);
      s6_color <= color_in;
    end
  end

  always_comb begin
    sum_x = sx_t'(s6_mx) + (sx_t'(offx) <<< FIN_SH) + (sx_t'(1) <<< (FIN_SH - 1));
    sum_y = sy_t'(s6_my) + (sy_t'(offy) <<< FIN_SH) + (sy_t'(1) <<< (FIN_SH - 1));
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      screen_x   <= sat_out(wide_t'(sum_x >>> FIN_SH));
      screen_y   <= sat_out(wide_t'(sum_y >>> FIN_SH));
      view_depth <= sat_out(wide_t'(s6_rz));
      color_out  <= s6_color;
    end
  end

endmodule

### hw/rtl/point_rotate_project_3d_core.sv
// ----------------------------------------------------------------------------
// point_rotate_project_3d_core
// Grid vertex to screen projection: rotation about Y then X, or oblique shear.
// ----------------------------------------------------------------------------
// Takes one vertex beat per clock while in_stall is low and returns one
// projected beat per vertex, in order. The seven register stages are:
// centering, first trig products, rotation sums, second trig products,
// rounding, zoom multiply, offset/round/saturate. Each stage holds only
// while it is full and the stage after it cannot move, so bubbles close up
// and a stalled output still lets the pipe fill behind it.
// Throughput is one vertex per cycle without out_stall; the product stages bound the clock.
// Trig words are signed Q2.14, scale is unsigned Q8.8, and screen_x,
// screen_y and view_depth round to nearest (halves up) and saturate to
// 16 bits signed. Color passes through unchanged. Write configuration only
// while the pipeline is empty; cfg_ready is always high.
// ----------------------------------------------------------------------------
module point_rotate_project_3d_core
  import prp3d_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // vertex input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [COL_W-1:0]         col,
  input  logic [COL_W-1:0]         row,
  input  logic signed [ELEV_W-1:0] elevation,
  input  logic [COLOR_W-1:0]       color,
  // projected output channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [OUT_W-1:0]  screen_x,
  output logic signed [OUT_W-1:0]  screen_y,
  output logic signed [OUT_W-1:0]  view_depth,
  output logic [COLOR_W-1:0]       color_out,
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  cfg_t   cfg;

  logic   c_up_en, c_v;
  cx_t    c_cx2, c_cy2;
  cz_t    c_cz2;
  color_t c_color;

  logic   r_up_en, r_v;
  px_t    r_px;
  py_t    r_py;
  pz_t    r_pz;
  color_t r_color;

  logic   s_up_en;

  prp3d_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage 1: center on the map
  prp3d_center u_center (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .v_in      (in_valid),
    .up_en     (c_up_en),
    .col       (col),
    .row       (row),
    .elevation (elevation),
    .color     (color),
    .v_out     (c_v),
    .down_en   (r_up_en),
    .cx2       (c_cx2),
    .cy2       (c_cy2),
    .cz2       (c_cz2),
    .color_q   (c_color)
  );

  // Stages 2..5: rotate or shear
  prp3d_rotate u_rotate (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .v_in     (c_v),
    .up_en    (r_up_en),
    .cx2      (c_cx2),
    .cy2      (c_cy2),
    .cz2      (c_cz2),
    .color_in (c_color),
    .v_out    (r_v),
    .down_en  (s_up_en),
    .px       (r_px),
    .py       (r_py),
    .pz       (r_pz),
    .color_q  (r_color)
  );

  // Stages 6..7: zoom, offset, saturate
  prp3d_screen u_screen (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .v_in       (r_v),
    .up_en      (s_up_en),
    .px         (r_px),
    .py         (r_py),
    .pz         (r_pz),
    .color_in   (r_color),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .screen_x   (screen_x),
    .screen_y   (screen_y),
    .view_depth (view_depth),
    .color_out  (color_out)
  );

  // Hold the input only when the first stage is full and cannot advance
  assign in_stall = !c_up_en;

`ifndef SYNTH
  a_free_out_takes_in: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while the output side was free");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat valid right after reset");
`endif

endmodule
